### hw/rtl/assert_macros.svh
// assertion macros shared by the quaternion unit rtl
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside reset
`define QAU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// property checked on every clock, reset included
`define QAU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### hw/rtl/qau_pkg.sv
// types, constants and helpers of the quaternion arithmetic unit
// no dependencies
package qau_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int QDEPTH        = 4;
    localparam int QW            = $clog2(QDEPTH);
    localparam int SAT_W         = 64;

    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_SCALE = 3'd2,
        CMD_HAM   = 3'd3,
        CMD_ROT   = 3'd4
    } t_cmd;

    // one-hot operation class made by the front
    typedef enum logic [5:0] {
        OP_NONE  = 6'b000001,
        OP_ADD   = 6'b000010,
        OP_SUB   = 6'b000100,
        OP_SCALE = 6'b001000,
        OP_HAM   = 6'b010000,
        OP_ROT   = 6'b100000
    } t_op;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] r_w;
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
    } t_out;

    typedef struct packed {
        t_op op;
        t_in data;
    } t_item;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'(signed'(32'h7fffffff));
        lo = SAT_W'(signed'(32'h80000000));
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return 32'(v);
    endfunction

endpackage

### hw/rtl/qau_front.sv
// front: takes input beats, classifies the command, hands items to the queue
// depends on qau_pkg
module qau_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  qau_pkg::t_in      i_item,
    output logic              o_push,
    input  logic              i_push_rdy,
    output qau_pkg::t_item    o_item
);

    logic           r_vld;
    qau_pkg::t_item r_item;
    qau_pkg::t_op   w_op;

    always_comb begin
        unique case (i_item.command)
            qau_pkg::CMD_ADD:   w_op = qau_pkg::OP_ADD;
            qau_pkg::CMD_SUB:   w_op = qau_pkg::OP_SUB;
            qau_pkg::CMD_SCALE: w_op = qau_pkg::OP_SCALE;
            qau_pkg::CMD_HAM:   w_op = qau_pkg::OP_HAM;
            qau_pkg::CMD_ROT:   w_op = qau_pkg::OP_ROT;
            default:            w_op = qau_pkg::OP_NONE;
        endcase
    end

    assign o_ready = !r_vld || i_push_rdy;
    assign o_push  = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_push_rdy) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.op   <= w_op;
            r_item.data <= i_item;
        end
    end

endmodule

### hw/rtl/qau_queue.sv
// short queue between front and back
// depends on qau_pkg and assert_macros.svh
`include "assert_macros.svh"
module qau_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_push_rdy,
    input  qau_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_pop,
    output qau_pkg::t_item    o_item
);

    qau_pkg::t_item              r_mem [qau_pkg::QDEPTH];
    logic [qau_pkg::QW-1:0]      r_wr;
    logic [qau_pkg::QW-1:0]      r_rd;
    logic [qau_pkg::QW:0]        r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_push_rdy = (r_count != (qau_pkg::QW+1)'(qau_pkg::QDEPTH));
    assign o_valid    = (r_count != '0);
    assign o_item     = r_mem[r_rd];
    assign w_push     = i_push && o_push_rdy;
    assign w_pop      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `QAU_ASSERT(a_count_bound, r_count <= (qau_pkg::QW+1)'(qau_pkg::QDEPTH), "queue count over depth")
    `QAU_ASSERT(a_ptr_gap, r_wr == r_rd + qau_pkg::QW'(r_count), "queue pointers disagree with count")

endmodule

### hw/rtl/qau_back.sv
// back: four-stage pipelined quaternion datapath with output register
// depends on qau_pkg and assert_macros.svh
`include "assert_macros.svh"
module qau_back #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fvalid,
    output logic              o_pop,
    input  qau_pkg::t_item    i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output qau_pkg::t_out     o_result
);

    localparam int PW = 64 - FRAC_BITS;

    function automatic logic signed [PW-1:0] fmul(input logic signed [31:0] x,
                                                  input logic signed [31:0] y);
        logic signed [63:0] p;
        p = x * y;
        return PW'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [qau_pkg::SAT_W-1:0] ext(input logic signed [PW+2:0] v);
        return qau_pkg::SAT_W'(v);
    endfunction

    logic [3:0] r_vld;
    logic       w_adv;

    assign w_adv   = !r_vld[3] || i_ready;
    assign o_pop   = w_adv && i_fvalid;
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[2:0], i_fvalid};
        end
    end

    // stage 1: all sixteen shifted products
    logic signed [31:0]   w_a [4];
    logic signed [31:0]   w_b [4];
    logic signed [PW-1:0] r1_p [4][4];
    qau_pkg::t_op         r1_op;
    logic signed [31:0]   r1_a [4];
    logic signed [31:0]   r1_b [4];

    assign w_a[0] = i_item.data.a_w;
    assign w_a[1] = i_item.data.a_x;
    assign w_a[2] = i_item.data.a_y;
    assign w_a[3] = i_item.data.a_z;
    assign w_b[0] = i_item.data.b_w;
    assign w_b[1] = i_item.data.b_x;
    assign w_b[2] = i_item.data.b_y;
    assign w_b[3] = i_item.data.b_z;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_op <= i_item.op;
            for (int i = 0; i < 4; i++) begin
                r1_a[i] <= w_a[i];
                r1_b[i] <= w_b[i];
                for (int j = 0; j < 4; j++) begin
                    r1_p[i][j] <= fmul(w_a[i], w_b[j]);
                end
            end
        end
    end

    // stage 2: sums for the simple commands, first cross product for rotate
    logic signed [31:0] w2_r [4];
    logic signed [31:0] w2_u [3];
    logic signed [31:0] r2_r [4];
    logic signed [31:0] r2_u [3];
    logic signed [31:0] r2_a [4];
    logic signed [31:0] r2_v [3];
    qau_pkg::t_op       r2_op;

    always_comb begin
        logic signed [PW+2:0] h [4];
        h[0] = (PW+3)'(r1_p[0][0]) - (PW+3)'(r1_p[1][1]) - (PW+3)'(r1_p[2][2])
             - (PW+3)'(r1_p[3][3]);
        h[1] = (PW+3)'(r1_p[0][1]) + (PW+3)'(r1_p[1][0]) + (PW+3)'(r1_p[2][3])
             - (PW+3)'(r1_p[3][2]);
        h[2] = (PW+3)'(r1_p[0][2]) + (PW+3)'(r1_p[2][0]) + (PW+3)'(r1_p[3][1])
             - (PW+3)'(r1_p[1][3]);
        h[3] = (PW+3)'(r1_p[0][3]) + (PW+3)'(r1_p[3][0]) + (PW+3)'(r1_p[1][2])
             - (PW+3)'(r1_p[2][1]);
        w2_u[0] = qau_pkg::sat32(ext((PW+3)'(r1_p[2][3]) - (PW+3)'(r1_p[3][2])));
        w2_u[1] = qau_pkg::sat32(ext((PW+3)'(r1_p[3][1]) - (PW+3)'(r1_p[1][3])));
        w2_u[2] = qau_pkg::sat32(ext((PW+3)'(r1_p[1][2]) - (PW+3)'(r1_p[2][1])));
        for (int i = 0; i < 4; i++) begin
            unique case (r1_op)
                qau_pkg::OP_ADD:
                    w2_r[i] = qau_pkg::sat32(qau_pkg::SAT_W'(r1_a[i])
                                             + qau_pkg::SAT_W'(r1_b[i]));
                qau_pkg::OP_SUB:
                    w2_r[i] = qau_pkg::sat32(qau_pkg::SAT_W'(r1_a[i])
                                             - qau_pkg::SAT_W'(r1_b[i]));
                qau_pkg::OP_SCALE:
                    w2_r[i] = qau_pkg::sat32(ext((PW+3)'(r1_p[i][0])));
                qau_pkg::OP_HAM:
                    w2_r[i] = qau_pkg::sat32(ext(h[i]));
                default:
                    w2_r[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_op <= r1_op;
            for (int i = 0; i < 4; i++) begin
                r2_r[i] <= w2_r[i];
                r2_a[i] <= r1_a[i];
            end
            for (int i = 0; i < 3; i++) begin
                r2_u[i] <= w2_u[i];
                r2_v[i] <= r1_b[i+1];
            end
        end
    end

    // stage 3: products of the rotor with u
    logic signed [PW-1:0] r3_q [3][3];
    logic signed [PW-1:0] r3_wu [3];
    logic signed [31:0]   r3_r [4];
    logic signed [31:0]   r3_v [3];
    qau_pkg::t_op         r3_op;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_op <= r2_op;
            for (int i = 0; i < 4; i++) begin
                r3_r[i] <= r2_r[i];
            end
            for (int i = 0; i < 3; i++) begin
                r3_v[i]  <= r2_v[i];
                r3_wu[i] <= fmul(r2_a[0], r2_u[i]);
                for (int j = 0; j < 3; j++) begin
                    r3_q[i][j] <= fmul(r2_a[i+1], r2_u[j]);
                end
            end
        end
    end

    // stage 4: second cross product, final rotate sum, output register
    logic signed [31:0] w4_t [3];
    logic signed [31:0] w4_rot [3];
    qau_pkg::t_out      r4_out;
    qau_pkg::t_op       r4_op;

    always_comb begin
        w4_t[0] = qau_pkg::sat32(ext((PW+3)'(r3_q[1][2]) - (PW+3)'(r3_q[2][1])));
        w4_t[1] = qau_pkg::sat32(ext((PW+3)'(r3_q[2][0]) - (PW+3)'(r3_q[0][2])));
        w4_t[2] = qau_pkg::sat32(ext((PW+3)'(r3_q[0][1]) - (PW+3)'(r3_q[1][0])));
        for (int i = 0; i < 3; i++) begin
            w4_rot[i] = qau_pkg::sat32(ext((PW+3)'(r3_v[i]) + ((PW+3)'(r3_wu[i]) <<< 1)
                                           + ((PW+3)'(w4_t[i]) <<< 1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_op <= r3_op;
            if (r3_op == qau_pkg::OP_ROT) begin
                r4_out <= {32'sd0, w4_rot[0], w4_rot[1], w4_rot[2]};
            end else begin
                r4_out <= {r3_r[0], r3_r[1], r3_r[2], r3_r[3]};
            end
        end
    end

    assign o_result = r4_out;

    `QAU_ASSERT(a_rot_w_zero, !(r_vld[3] && r4_op == qau_pkg::OP_ROT) || r4_out.r_w == '0, "rotate result has nonzero w")
    `QAU_ASSERT(a_stall_hold, !($past(r_vld[3]) && !$past(i_ready)) || $stable(r_vld), "pipeline moved while stalled")

endmodule

### hw/rtl/quaternion_arith_unit.sv
// quaternion arithmetic unit, top level
// result path: front register, queue entry, then the back pipeline stages ending in the output register
// throughput: one item per cycle while the sink does not stall, set by the fully pipelined back datapath
// the 4-entry queue lets front and back stall on their own
// reset: synchronous active-low i_rst_n clears all valid state, no clearing pass
// depends on qau_pkg, qau_front, qau_queue, qau_back
module quaternion_arith_unit #(
    parameter int FRAC_BITS = qau_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qau_pkg::t_in   i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output qau_pkg::t_out  o_result
);

    // front to queue
    logic           w_push;
    logic           w_push_rdy;
    qau_pkg::t_item w_front_item;

    // queue to back
    logic           w_qvalid;
    logic           w_pop;
    qau_pkg::t_item w_head;

    // accept and classify each input beat
    qau_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_push     (w_push),
        .i_push_rdy (w_push_rdy),
        .o_item     (w_front_item)
    );

    // decoupling queue
    qau_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_push_rdy (w_push_rdy),
        .i_item     (w_front_item),
        .o_valid    (w_qvalid),
        .i_pop      (w_pop),
        .o_item     (w_head)
    );

    // arithmetic pipeline, its last stage is the output register
    qau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fvalid (w_qvalid),
        .o_pop    (w_pop),
        .i_item   (w_head),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

endmodule

### tb/sv/tb_top.sv
// testbench for the quaternion arithmetic unit: directed and random commands
// with random idling on both sides, checked against an in-bench predictor
// depends on qau_pkg and quaternion_arith_unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = qau_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM   = 550;
    localparam int CALM_TAIL  = 60;     // last items run with no idling
    localparam int LATENCY    = 6;
    localparam int CYCLE_CAP  = 200000;

    logic           i_clk;
    logic           i_rst_n;
    logic           in_valid;
    logic           in_ready;
    qau_pkg::t_in   in_item;
    logic           out_valid;
    logic           out_ready;
    qau_pkg::t_out  out_result;
    logic           in_ready_seen;

    qau_pkg::t_in   pending_items[$];
    qau_pkg::t_out  expected_quats[$];
    int     items_total;
    int     items_sent;
    int     drive_gap;
    int     sink_gap;
    int     cycle_count;
    bit     failed;
    bit     stim_done;

    quaternion_arith_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .o_ready  (in_ready),
        .i_item   (in_item),
        .o_valid  (out_valid),
        .i_ready  (out_ready),
        .o_result (out_result)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // fixed-point product, floor shift of the exact 64-bit value
    function automatic longint fx_mul(input longint x, input longint y);
        longint p;
        p = x * y;
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // cross product p x q with every component clamped
    function automatic void cross3(input longint p[3], input longint q[3],
                                   output longint r[3]);
        r[0] = clamp32(fx_mul(p[1], q[2]) - fx_mul(p[2], q[1]));
        r[1] = clamp32(fx_mul(p[2], q[0]) - fx_mul(p[0], q[2]));
        r[2] = clamp32(fx_mul(p[0], q[1]) - fx_mul(p[1], q[0]));
    endfunction

    function automatic qau_pkg::t_out predict_quat(input qau_pkg::t_in it);
        longint a[4];
        longint b[4];
        longint r[4];
        longint qv[3];
        longint vv[3];
        longint u[3];
        longint t[3];
        longint wu;
        qau_pkg::t_out o;
        a[0] = it.a_w; a[1] = it.a_x; a[2] = it.a_y; a[3] = it.a_z;
        b[0] = it.b_w; b[1] = it.b_x; b[2] = it.b_y; b[3] = it.b_z;
        for (int i = 0; i < 4; i++) r[i] = 0;
        case (it.command)
            qau_pkg::CMD_ADD: begin
                for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] + b[i]);
            end
            qau_pkg::CMD_SUB: begin
                for (int i = 0; i < 4; i++) r[i] = clamp32(a[i] - b[i]);
            end
            qau_pkg::CMD_SCALE: begin
                for (int i = 0; i < 4; i++) r[i] = clamp32(fx_mul(a[i], b[0]));
            end
            qau_pkg::CMD_HAM: begin
                r[0] = clamp32(fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
                             - fx_mul(a[2], b[2]) - fx_mul(a[3], b[3]));
                r[1] = clamp32(fx_mul(a[0], b[1]) + fx_mul(a[1], b[0])
                             + fx_mul(a[2], b[3]) - fx_mul(a[3], b[2]));
                r[2] = clamp32(fx_mul(a[0], b[2]) + fx_mul(a[2], b[0])
                             + fx_mul(a[3], b[1]) - fx_mul(a[1], b[3]));
                r[3] = clamp32(fx_mul(a[0], b[3]) + fx_mul(a[3], b[0])
                             + fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
            end
            qau_pkg::CMD_ROT: begin
                for (int i = 0; i < 3; i++) begin
                    qv[i] = a[i+1];
                    vv[i] = b[i+1];
                end
                cross3(qv, vv, u);
                cross3(qv, u, t);
                for (int i = 0; i < 3; i++) begin
                    wu = fx_mul(a[0], u[i]);
                    r[i+1] = clamp32(vv[i] + wu + wu + t[i] + t[i]);
                end
            end
            default: begin
            end
        endcase
        o.r_w = 32'(r[0]);
        o.r_x = 32'(r[1]);
        o.r_y = 32'(r[2]);
        o.r_z = 32'(r[3]);
        return o;
    endfunction

    // component value: mostly modest magnitudes, some extremes and full range
    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2, 3:    return $urandom;
            4:       return 32'($urandom_range(0, 65536 * 4)) ^ {32{$urandom_range(0, 1) == 1}};
            default: return 32'(signed'($urandom_range(0, 65536 * 512)) - 65536 * 256);
        endcase
    endfunction

    function automatic qau_pkg::t_in make_item(input logic [2:0] cmd, input logic [31:0] v);
        qau_pkg::t_in it;
        it.command = cmd;
        it.a_w = v; it.a_x = v; it.a_y = v; it.a_z = v;
        it.b_w = v; it.b_x = v; it.b_y = v; it.b_z = v;
        return it;
    endfunction

    initial begin
        qau_pkg::t_in it;
        logic [31:0] edges[4];
        edges[0] = 32'h7fffffff;
        edges[1] = 32'h80000000;
        edges[2] = 32'h00010000;
        edges[3] = 32'hffffffff;
        // directed: every command (unused codes too) at the field extremes
        for (int c = 0; c < 8; c++) begin
            for (int e = 0; e < 2; e++) begin
                pending_items.push_back(make_item(3'(c), edges[e]));
            end
        end
        // mixed signs force saturation and floor rounding of negatives
        it = make_item(qau_pkg::CMD_ADD, 32'h7fffffff);
        it.b_w = 32'h80000000;
        pending_items.push_back(it);
        it = make_item(qau_pkg::CMD_SUB, 32'h80000000);
        it.b_x = 32'h7fffffff;
        pending_items.push_back(it);
        pending_items.push_back(make_item(qau_pkg::CMD_SCALE, edges[3]));
        pending_items.push_back(make_item(qau_pkg::CMD_HAM, edges[2]));
        it = make_item(qau_pkg::CMD_ROT, 32'h00010000);
        it.b_y = 32'hfffe0001;
        pending_items.push_back(it);
        pending_items.push_back(make_item(qau_pkg::CMD_ROT, 32'h00000000));
        for (int n = 0; n < N_RANDOM; n++) begin
            it.command = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
            it.a_w = rand_comp(); it.a_x = rand_comp();
            it.a_y = rand_comp(); it.a_z = rand_comp();
            it.b_w = rand_comp(); it.b_x = rand_comp();
            it.b_y = rand_comp(); it.b_z = rand_comp();
            pending_items.push_back(it);
        end
        items_total = pending_items.size();
    end

    // driver: new beat at the falling edge once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_item  <= '0;
            drive_gap = 0;
        end else begin
            if (in_valid && in_ready_seen) begin
                expected_quats.push_back(predict_quat(in_item));
                items_sent++;
            end
            if (!in_valid || in_ready_seen) begin
                if (drive_gap > 0) begin
                    drive_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item  <= pending_items.pop_front();
                    if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                        drive_gap = $urandom_range(1, 15);
                    end
                end else begin
                    in_valid <= 1'b0;
                    stim_done = 1'b1;
                end
            end
        end
    end

    // input acceptance as seen at the rising edge
    always @(posedge i_clk) begin
        in_ready_seen <= i_rst_n && in_valid && in_ready;
    end

    // sink ready: bursts of stall, none near the end
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            sink_gap = 0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (pending_items.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                sink_gap = $urandom_range(1, 15);
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        qau_pkg::t_out exp_q;
        if (i_rst_n && out_valid && out_ready) begin
            if (expected_quats.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $realtime, out_result);
                failed = 1'b1;
            end else begin
                exp_q = expected_quats.pop_front();
                if (out_result.r_w !== exp_q.r_w) begin
                    $display("%0t: r_w expected %h actual %h", $realtime, exp_q.r_w, out_result.r_w);
                    failed = 1'b1;
                end
                if (out_result.r_x !== exp_q.r_x) begin
                    $display("%0t: r_x expected %h actual %h", $realtime, exp_q.r_x, out_result.r_x);
                    failed = 1'b1;
                end
                if (out_result.r_y !== exp_q.r_y) begin
                    $display("%0t: r_y expected %h actual %h", $realtime, exp_q.r_y, out_result.r_y);
                    failed = 1'b1;
                end
                if (out_result.r_z !== exp_q.r_z) begin
                    $display("%0t: r_z expected %h actual %h", $realtime, exp_q.r_z, out_result.r_z);
                    failed = 1'b1;
                end
            end
        end
    end

    // run control, timeout and final verdict
    initial begin
        i_rst_n     = 1'b0;
        failed      = 1'b0;
        stim_done   = 1'b0;
        items_sent  = 0;
        cycle_count = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!(stim_done && expected_quats.size() == 0) && cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        if (cycle_count >= CYCLE_CAP) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            repeat (LATENCY * 4) @(posedge i_clk);
            if (!failed && expected_quats.size() == 0 && items_sent == items_total) begin
                $display("TEST PASSED");
            end else begin
                $display("TEST FAILED");
            end
            $finish;
        end
    end

endmodule
